>>> rtl/core/tbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket shaper package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package tbps_pkg;

  // Configuration port layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int DEPTH_W    = 4;
  localparam int LIMIT_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 2'd1;

  localparam logic [DEPTH_W-1:0] BUCKET_DEPTH_RST = 4'd5;
  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST  = 5'd10;

  // Request kinds
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ARRIVAL = 1'b1;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // take the request, update bucket and queue
    logic emit;   // read the head word and present the result
  } cmd_t;

endpackage

>>> rtl/core/token_bucket_packet_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket packet shaper
// Token bucket in front of a bounded packet FIFO; one result per request.
// ----------------------------------------------------------------------------
// A taken request updates the bucket and queue registers; the read step then
// does the registered store read, and the result strobe follows it.
// No new request is taken until the read step ends; busy is high for it.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (synchronous, active low): bucket and queue empty, depth 5, limit 10.
module token_bucket_packet_shaper #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32,
  parameter int TOKEN_MAX   = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_op,
  input  logic [DATA_WIDTH-1:0]                in_packet_data,
  output logic                                 out_valid,
  output logic                                 out_sent,
  output logic [DATA_WIDTH-1:0]                out_sent_data,
  output logic                                 out_dropped,
  output logic [$clog2(TOKEN_MAX+1)-1:0]       out_tokens_left,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_queue_fill,
  input  logic                                 cfg_we,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  tbps_pkg::cmd_t cmd;

  // Sequence each request
  tbps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Bucket, FIFO and result registers
  tbps_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH),
    .TOKEN_MAX   (TOKEN_MAX)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_op),
    .in_packet_data  (in_packet_data),
    .out_valid       (out_valid),
    .out_sent        (out_sent),
    .out_sent_data   (out_sent_data),
    .out_dropped     (out_dropped),
    .out_tokens_left (out_tokens_left),
    .out_queue_fill  (out_queue_fill)
  );

endmodule

>>> rtl/core/tbps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket shaper controller
// Two-state sequencer: take a request, then read the store and emit a result.
// ----------------------------------------------------------------------------
module tbps_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output tbps_pkg::cmd_t  cmd
);

  tbps_pkg::state_t state_r;
  tbps_pkg::state_t state_nxt;

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbps_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tbps_pkg::ST_READ;
        end
      end
      tbps_pkg::ST_READ: begin
        state_nxt = tbps_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tbps_pkg::ST_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.emit = 1'b0;
    unique case (state_r)
      tbps_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      tbps_pkg::ST_READ: begin
        busy     = 1'b1;
        cmd.emit = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && cmd.emit))
    else $error("accepted request did not move to the read step");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (!busy && !cmd.emit))
    else $error("read step lasted more than one cycle");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.emit))
    else $error("load and emit issued together");
`endif

endmodule

>>> rtl/core/tbps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket shaper datapath
// Token counter, packet FIFO with pointers, config registers and result regs.
// ----------------------------------------------------------------------------
module tbps_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32,
  parameter int TOKEN_MAX   = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tbps_pkg::cmd_t                       cmd,
  input  logic                                 cfg_we,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_op,
  input  logic [DATA_WIDTH-1:0]                in_packet_data,
  output logic                                 out_valid,
  output logic                                 out_sent,
  output logic [DATA_WIDTH-1:0]                out_sent_data,
  output logic                                 out_dropped,
  output logic [$clog2(TOKEN_MAX+1)-1:0]       out_tokens_left,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_queue_fill
);

  localparam int TW = $clog2(TOKEN_MAX + 1);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int DW = (TW > tbps_pkg::DEPTH_W) ? TW : tbps_pkg::DEPTH_W;
  localparam int LW = (CW > tbps_pkg::LIMIT_W) ? CW : tbps_pkg::LIMIT_W;

  // Configuration
  logic [tbps_pkg::DEPTH_W-1:0] cfg_depth_r;
  logic [tbps_pkg::LIMIT_W-1:0] cfg_limit_r;

  // Bucket and queue state
  logic [TW-1:0]         tok_r,    tok_nxt;
  logic [CW-1:0]         cnt_r,    cnt_nxt;
  logic [PW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]         head_r;
  logic                  send_r,   send_nxt;
  logic                  drop_r,   drop_nxt;
  logic                  enq_nxt;
  logic                  valid_r;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];

  // Working values
  logic [DW-1:0] depth_w, tok_w, tok_mid;
  logic [LW-1:0] limit_w, cnt_w, cnt_mid;

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_depth_r <= tbps_pkg::BUCKET_DEPTH_RST;
      cfg_limit_r <= tbps_pkg::QUEUE_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == tbps_pkg::REG_BUCKET_DEPTH) begin
        cfg_depth_r <= cfg_wdata[tbps_pkg::DEPTH_W-1:0];
      end else if (cfg_index == tbps_pkg::REG_QUEUE_LIMIT) begin
        cfg_limit_r <= cfg_wdata[tbps_pkg::LIMIT_W-1:0];
      end
    end
  end

  // Work out the bucket and queue update for one request
  always_comb begin
    depth_w = (DW'(cfg_depth_r) > DW'(TOKEN_MAX)) ? DW'(TOKEN_MAX) : DW'(cfg_depth_r);
    limit_w = (LW'(cfg_limit_r) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : LW'(cfg_limit_r);
    tok_w   = DW'(tok_r);
    cnt_w   = LW'(cnt_r);
    enq_nxt  = 1'b0;
    drop_nxt = 1'b0;
    if (in_op == tbps_pkg::OP_TICK) begin
      tok_mid = (tok_w < depth_w) ? tok_w + DW'(1) : tok_w;
      cnt_mid = cnt_w;
    end else begin
      enq_nxt  = (cnt_w < limit_w);
      drop_nxt = !enq_nxt;
      tok_mid  = tok_w;
      cnt_mid  = cnt_w + LW'(enq_nxt);
    end
    send_nxt = (cnt_mid != '0) && (tok_mid != '0);
    tok_nxt  = TW'(tok_mid - DW'(send_nxt));
    cnt_nxt  = CW'(cnt_mid - LW'(send_nxt));
    // Advance pointers with wrap at the queue depth
    rd_ptr_nxt = rd_ptr_r;
    if (send_nxt) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    wr_ptr_nxt = wr_ptr_r;
    if (enq_nxt) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
  end

  // Hold bucket, queue and result control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= '0;
      cnt_r    <= '0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      send_r   <= 1'b0;
      drop_r   <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      if (cmd.load) begin
        tok_r    <= tok_nxt;
        cnt_r    <= cnt_nxt;
        rd_ptr_r <= rd_ptr_nxt;
        wr_ptr_r <= wr_ptr_nxt;
        send_r   <= send_nxt;
        drop_r   <= drop_nxt;
      end
    end
  end

  // Latch the head address for the read step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      head_r <= rd_ptr_r;
    end
  end

  // Packet store: write on enqueue, registered read of the head
  always_ff @(posedge clk) begin
    if (cmd.load && enq_nxt) begin
      mem[wr_ptr_r] <= in_packet_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rd_data_r <= mem[head_r];
    end
  end

  // Drive results
  assign out_valid       = valid_r;
  assign out_sent        = send_r;
  assign out_sent_data   = send_r ? rd_data_r : '0;
  assign out_dropped     = drop_r;
  assign out_tokens_left = tok_r;
  assign out_queue_fill  = cnt_r;

`ifndef SYNTH
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(cnt_r) <= CW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_tokens_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    TW'(tok_r) <= TW'(TOKEN_MAX))
    else $error("token count beyond maximum");

  a_send_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && send_nxt) |=> (rd_ptr_r != $past(rd_ptr_r)))
    else $error("packet sent without advancing the read pointer");
`endif

endmodule

>>> bench/tb_token_bucket_packet_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket packet shaper testbench
// Drives tick and arrival requests through the start/busy port. Idle gaps
// fall at random. The bucket depth and queue limit are rewritten between
// phases while the block is idle. A scoreboard class keeps its own bucket
// and FIFO, predicts each result and compares every strobed result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_token_bucket_packet_shaper;

  localparam int  CLK_HI        = 6;
  localparam int  CLK_LO        = 6;
  localparam int  RESET_CYCLES  = 7;
  localparam int  TOKEN_LIMIT   = 15;
  localparam int  FIFO_SLOTS    = 16;
  localparam int  RAND_PHASES   = 15;
  localparam int  PHASE_ITEMS   = 50;
  localparam int  QUIET_PHASES  = 2;
  localparam int  DRAIN_BOUND   = 64;
  localparam int  SETTLE_CYCLES = 6;
  localparam longint CYCLE_LIMIT = 200000;

  typedef logic [tbps_pkg::CFG_DATA_W-1:0] cfg_word_t;

  // Indexes with no register behind them
  localparam logic [tbps_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [tbps_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic        sent;
    logic [31:0] sent_data;
    logic        dropped;
    logic [3:0]  tokens_left;
    logic [4:0]  queue_fill;
  } shaper_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: bucket and FIFO predictor plus the queue of predicted results
  // --------------------------------------------------------------------------
  class shaper_scoreboard;
    logic [tbps_pkg::DEPTH_W-1:0] bucket_depth;
    logic [tbps_pkg::LIMIT_W-1:0] queue_limit;
    int                 tokens;
    logic [31:0]        waiting_packets[$];
    shaper_result_t     predicted[$];
    int                 errors;

    function new();
      bucket_depth = tbps_pkg::BUCKET_DEPTH_RST;
      queue_limit  = tbps_pkg::QUEUE_LIMIT_RST;
      tokens       = 0;
      errors       = 0;
    endfunction

    task report(input string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function int pending();
      return predicted.size();
    endfunction

    // Apply a register write; unknown indexes change nothing
    function void write_reg(input logic [tbps_pkg::CFG_IDX_W-1:0] idx,
                            input logic [tbps_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tbps_pkg::REG_BUCKET_DEPTH: bucket_depth = data[tbps_pkg::DEPTH_W-1:0];
        tbps_pkg::REG_QUEUE_LIMIT:  queue_limit  = data[tbps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the bucket and FIFO by one accepted request
    function void note_request(input logic op, input logic [31:0] data);
      shaper_result_t r;
      int depth_cap;
      int limit_cap;
      depth_cap = (bucket_depth > TOKEN_LIMIT) ? TOKEN_LIMIT : bucket_depth;
      limit_cap = (queue_limit > FIFO_SLOTS) ? FIFO_SLOTS : queue_limit;
      r = '0;
      if (op == tbps_pkg::OP_TICK) begin
        if (tokens < depth_cap) tokens++;
      end else begin
        if (waiting_packets.size() < limit_cap) waiting_packets.push_back(data);
        else r.dropped = 1'b1;
      end
      // Send the head packet when a token and a packet are both present
      if (tokens > 0 && waiting_packets.size() > 0) begin
        r.sent      = 1'b1;
        r.sent_data = waiting_packets.pop_front();
        tokens--;
      end
      r.tokens_left = tokens[3:0];
      r.queue_fill  = 5'(waiting_packets.size());
      predicted.push_back(r);
    endfunction

    // Compare one strobed result with the oldest prediction
    task check_result(input shaper_result_t got);
      shaper_result_t want;
      if (predicted.size() == 0) begin
        report("result with nothing predicted");
      end else begin
        want = predicted.pop_front();
        if (got.sent !== want.sent)
          report($sformatf("sent %0b, predicted %0b", got.sent, want.sent));
        if (got.sent_data !== want.sent_data)
          report($sformatf("sent_data %h, predicted %h", got.sent_data, want.sent_data));
        if (got.dropped !== want.dropped)
          report($sformatf("dropped %0b, predicted %0b", got.dropped, want.dropped));
        if (got.tokens_left !== want.tokens_left)
          report($sformatf("tokens_left %0d, predicted %0d",
                           got.tokens_left, want.tokens_left));
        if (got.queue_fill !== want.queue_fill)
          report($sformatf("queue_fill %0d, predicted %0d",
                           got.queue_fill, want.queue_fill));
      end
    endtask

    // Count and discard predictions that never got a result
    task flush_leftover();
      while (predicted.size() > 0) begin
        report("predicted result never arrived");
        void'(predicted.pop_front());
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and instance
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_op = tbps_pkg::OP_TICK;
  logic [31:0]           in_packet_data = '0;
  logic                  out_valid;
  logic                  out_sent;
  logic [31:0]           out_sent_data;
  logic                  out_dropped;
  logic [3:0]            out_tokens_left;
  logic [4:0]            out_queue_fill;
  logic                  cfg_we = 1'b0;
  logic [tbps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tbps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  longint                cycle_count = 0;

  shaper_scoreboard sb = new();

  token_bucket_packet_shaper u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_packet_data  (in_packet_data),
    .out_valid       (out_valid),
    .out_sent        (out_sent),
    .out_sent_data   (out_sent_data),
    .out_dropped     (out_dropped),
    .out_tokens_left (out_tokens_left),
    .out_queue_fill  (out_queue_fill),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #CLK_HI clk = 1'b1;
    #CLK_LO clk = 1'b0;
  end

  // Take each strobed result at the edge that ends its cycle
  always @(posedge clk) begin
    shaper_result_t got;
    if (rst_n && out_valid) begin
      got.sent        = out_sent;
      got.sent_data   = out_sent_data;
      got.dropped     = out_dropped;
      got.tokens_left = out_tokens_left;
      got.queue_fill  = out_queue_fill;
      sb.check_result(got);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_token_bucket_packet_shaper: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  // Present one request and hold it until the block takes it
  task automatic issue_request(input logic op, input logic [31:0] data);
    @(negedge clk);
    start          <= 1'b1;
    in_op          <= op;
    in_packet_data <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, data);
  endtask

  // Drop start for a number of cycles
  task automatic idle_cycles(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_register(input logic [tbps_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tbps_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Wait for every predicted result, then let the pipeline empty
  task automatic drain_and_settle();
    int waited;
    waited = 0;
    idle_cycles(1);
    while (sb.pending() > 0 && waited < DRAIN_BOUND) begin
      @(posedge clk);
      waited++;
    end
    sb.flush_leftover();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_payload();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One stretch of random requests with a given share of arrivals
  task automatic run_phase(input int n, input int arrival_pct, input bit with_gaps);
    logic op;
    for (int i = 0; i < n; i++) begin
      if (with_gaps && $urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 18));
      op = ($urandom_range(0, 99) < arrival_pct) ? tbps_pkg::OP_ARRIVAL : tbps_pkg::OP_TICK;
      issue_request(op, pick_payload());
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [tbps_pkg::CFG_DATA_W-1:0] depth_plan[6] =
    '{5'h00, 5'h1F, 5'h01, 5'h0F, 5'h13, 5'h01};
  logic [tbps_pkg::CFG_DATA_W-1:0] limit_plan[6] =
    '{5'h00, 5'h00, 5'h1F, 5'h10, 5'h11, 5'h01};
  int arrival_share[3] = '{20, 50, 80};

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: fill the bucket past its depth, spend it, then overflow the queue
    repeat (6) issue_request(tbps_pkg::OP_TICK, 32'h0);
    issue_request(tbps_pkg::OP_ARRIVAL, 32'h0000_0000);
    issue_request(tbps_pkg::OP_ARRIVAL, 32'hFFFF_FFFF);
    idle_cycles(3);
    issue_request(tbps_pkg::OP_ARRIVAL, 32'hA5A5_A5A5);
    issue_request(tbps_pkg::OP_ARRIVAL, 32'h0000_0000);
    issue_request(tbps_pkg::OP_ARRIVAL, 32'hFFFF_FFFF);
    for (int i = 0; i < 11; i++)
      issue_request(tbps_pkg::OP_ARRIVAL, (i % 2) ? 32'hFFFF_FFFF : $urandom);
    issue_request(tbps_pkg::OP_TICK, 32'hFFFF_FFFF);
    drain_and_settle();

    // Writes to indexes with no register must leave both settings alone
    write_register(REG_SPARE_A, 5'h1F);
    write_register(REG_SPARE_B, 5'h00);

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 6) begin
        write_register(tbps_pkg::REG_BUCKET_DEPTH, depth_plan[p]);
        write_register(tbps_pkg::REG_QUEUE_LIMIT, limit_plan[p]);
      end else begin
        if ($urandom_range(0, 3) == 0)
          write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                         cfg_word_t'($urandom));
        write_register(tbps_pkg::REG_BUCKET_DEPTH, cfg_word_t'($urandom));
        write_register(tbps_pkg::REG_QUEUE_LIMIT,
                       $urandom_range(0, 3) == 0 ? cfg_word_t'($urandom_range(0, 31))
                                                 : cfg_word_t'($urandom_range(1, 16)));
      end
      run_phase(PHASE_ITEMS, arrival_share[$urandom_range(0, 2)],
                (p < RAND_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0));
      drain_and_settle();
    end

    if (sb.errors == 0) begin
      $display("tb_token_bucket_packet_shaper: clean");
    end else begin
      $display("tb_token_bucket_packet_shaper: errors");
    end
    $finish;
  end

endmodule
